// File: rtl/core/sexpr_byte_tokenizer_defines.svh
// Assertion macros shared by the tokenizer RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef SEXPR_BYTE_TOKENIZER_DEFINES_SVH
`define SEXPR_BYTE_TOKENIZER_DEFINES_SVH
`ifndef ASSERT_OFF
`define SBT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sbt assertion failed");
`define SBT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sbt assertion failed");
`else
`define SBT_ASSERT(label, clk, rst_n, prop)
`define SBT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: rtl/core/sbt_pkg.sv
// Types, codes and character constants of the byte tokenizer.
// Used by sbt_lexer, sbt_event_fifo and sexpr_byte_tokenizer.
package sbt_pkg;

  localparam int MaxNestingDef = 16;
  localparam int MaxEvents     = 3;
  localparam int EvCntW        = 2;

  localparam logic [7:0] ChLParen    = 8'h28;
  localparam logic [7:0] ChRParen    = 8'h29;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;

  typedef enum logic [5:0] {
    ModeIdle = 6'b000001,
    ModeList = 6'b000010,
    ModeSym  = 6'b000100,
    ModeStr  = 6'b001000,
    ModeEsc  = 6'b010000,
    ModeHalt = 6'b100000
  } mode_e;

  typedef enum logic [3:0] {
    EvOpen     = 4'd0,
    EvClose    = 4'd1,
    EvSymByte  = 4'd2,
    EvSymEnd   = 4'd3,
    EvStrStart = 4'd4,
    EvStrByte  = 4'd5,
    EvStrEnd   = 4'd6,
    EvDone     = 4'd7,
    EvError    = 4'd8
  } event_kind_e;

  typedef enum logic [2:0] {
    ErrUnterm = 3'd0,
    ErrDeep   = 3'd1,
    ErrUnbal  = 3'd2,
    ErrClose  = 3'd3,
    ErrEmpty  = 3'd4
  } error_code_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } sbt_in_t;

  typedef struct packed {
    logic [3:0] event_kind;
    logic [7:0] char_value;
    logic [7:0] nest_level;
    logic [2:0] error_code;
    logic       last_of_run;
  } sbt_out_t;

  typedef struct packed {
    logic [EvCntW-1:0]           count;
    sbt_out_t [MaxEvents-1:0]    ev;
  } sbt_batch_t;

endpackage

// File: rtl/core/sbt_lexer.sv
// Lexer state registers and the per-byte event logic of the tokenizer.
// Depends on sbt_pkg and sexpr_byte_tokenizer_defines.svh.
`include "sexpr_byte_tokenizer_defines.svh"
module sbt_lexer #(
  parameter int MaxNesting = sbt_pkg::MaxNestingDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  sbt_pkg::sbt_in_t   in_data_i,
  output sbt_pkg::sbt_batch_t batch_o
);

  sbt_pkg::mode_e mode_q, mode_d;
  logic [7:0]     depth_q, depth_d;
  sbt_pkg::sbt_out_t [sbt_pkg::MaxEvents-1:0] ev_d;
  logic [sbt_pkg::EvCntW-1:0] n_d;
  logic           do_start;
  logic [7:0]     c;
  logic           is_blank;
  logic           is_delim;

  function automatic sbt_pkg::sbt_out_t mk_ev(logic [3:0] kind, logic [7:0] ch,
                                              logic [7:0] lvl, logic [2:0] err);
    sbt_pkg::sbt_out_t e;
    e.event_kind  = kind;
    e.char_value  = ch;
    e.nest_level  = lvl;
    e.error_code  = err;
    e.last_of_run = 1'b0;
    return e;
  endfunction

  assign c        = in_data_i.data_byte;
  assign is_blank = c inside {sbt_pkg::ChSpace, sbt_pkg::ChTab, sbt_pkg::ChLf, sbt_pkg::ChCr};
  assign is_delim = is_blank || (c inside {sbt_pkg::ChLParen, sbt_pkg::ChRParen,
                                           sbt_pkg::ChQuote});

  always_comb begin
    mode_d   = mode_q;
    depth_d  = depth_q;
    ev_d     = '0;
    n_d      = '0;
    do_start = 1'b0;
    if (in_data_i.end_of_text) begin
      case (mode_q)
        sbt_pkg::ModeIdle: begin
          ev_d[n_d] = mk_ev(sbt_pkg::EvError, 8'd0, depth_q, sbt_pkg::ErrEmpty);
          n_d = n_d + 2'd1;
        end
        sbt_pkg::ModeList: begin
          ev_d[n_d] = mk_ev(sbt_pkg::EvError, 8'd0, depth_q, sbt_pkg::ErrUnbal);
          n_d = n_d + 2'd1;
        end
        sbt_pkg::ModeSym: begin
          ev_d[n_d] = mk_ev(sbt_pkg::EvSymEnd, 8'd0, depth_q, 3'd0);
          n_d = n_d + 2'd1;
          if (depth_q == 8'd0) begin
            ev_d[n_d] = mk_ev(sbt_pkg::EvDone, 8'd0, depth_q, 3'd0);
          end else begin
            ev_d[n_d] = mk_ev(sbt_pkg::EvError, 8'd0, depth_q, sbt_pkg::ErrUnbal);
          end
          n_d = n_d + 2'd1;
        end
        sbt_pkg::ModeStr, sbt_pkg::ModeEsc: begin
          ev_d[n_d] = mk_ev(sbt_pkg::EvError, 8'd0, depth_q, sbt_pkg::ErrUnterm);
          n_d = n_d + 2'd1;
        end
        default: begin
        end
      endcase
      mode_d  = sbt_pkg::ModeIdle;
      depth_d = 8'd0;
    end else begin
      case (mode_q)
        sbt_pkg::ModeIdle, sbt_pkg::ModeList: begin
          do_start = 1'b1;
        end
        sbt_pkg::ModeSym: begin
          if (!is_delim) begin
            ev_d[n_d] = mk_ev(sbt_pkg::EvSymByte, c, depth_q, 3'd0);
            n_d = n_d + 2'd1;
          end else begin
            ev_d[n_d] = mk_ev(sbt_pkg::EvSymEnd, 8'd0, depth_q, 3'd0);
            n_d = n_d + 2'd1;
            if (depth_q == 8'd0) begin
              ev_d[n_d] = mk_ev(sbt_pkg::EvDone, 8'd0, depth_q, 3'd0);
              n_d = n_d + 2'd1;
              mode_d = sbt_pkg::ModeHalt;
            end else begin
              mode_d   = sbt_pkg::ModeList;
              do_start = 1'b1;
            end
          end
        end
        sbt_pkg::ModeStr: begin
          if (c == sbt_pkg::ChBackslash) begin
            mode_d = sbt_pkg::ModeEsc;
          end else if (c == sbt_pkg::ChQuote) begin
            ev_d[n_d] = mk_ev(sbt_pkg::EvStrEnd, 8'd0, depth_q, 3'd0);
            n_d = n_d + 2'd1;
            if (depth_q == 8'd0) begin
              ev_d[n_d] = mk_ev(sbt_pkg::EvDone, 8'd0, depth_q, 3'd0);
              n_d = n_d + 2'd1;
              mode_d = sbt_pkg::ModeHalt;
            end else begin
              mode_d = sbt_pkg::ModeList;
            end
          end else begin
            ev_d[n_d] = mk_ev(sbt_pkg::EvStrByte, c, depth_q, 3'd0);
            n_d = n_d + 2'd1;
          end
        end
        sbt_pkg::ModeEsc: begin
          ev_d[n_d] = mk_ev(sbt_pkg::EvStrByte, c, depth_q, 3'd0);
          n_d = n_d + 2'd1;
          mode_d = sbt_pkg::ModeStr;
        end
        default: begin
        end
      endcase

      if (do_start && !is_blank) begin
        if (c == sbt_pkg::ChLParen) begin
          if (depth_q >= 8'(MaxNesting)) begin
            ev_d[n_d] = mk_ev(sbt_pkg::EvError, 8'd0, depth_q, sbt_pkg::ErrDeep);
            n_d = n_d + 2'd1;
            mode_d = sbt_pkg::ModeHalt;
          end else begin
            depth_d = depth_q + 8'd1;
            ev_d[n_d] = mk_ev(sbt_pkg::EvOpen, 8'd0, depth_d, 3'd0);
            n_d = n_d + 2'd1;
            mode_d = sbt_pkg::ModeList;
          end
        end else if (c == sbt_pkg::ChRParen) begin
          if (depth_q == 8'd0) begin
            ev_d[n_d] = mk_ev(sbt_pkg::EvError, 8'd0, depth_q, sbt_pkg::ErrClose);
            n_d = n_d + 2'd1;
            mode_d = sbt_pkg::ModeHalt;
          end else begin
            depth_d = depth_q - 8'd1;
            ev_d[n_d] = mk_ev(sbt_pkg::EvClose, 8'd0, depth_d, 3'd0);
            n_d = n_d + 2'd1;
            if (depth_d == 8'd0) begin
              ev_d[n_d] = mk_ev(sbt_pkg::EvDone, 8'd0, depth_d, 3'd0);
              n_d = n_d + 2'd1;
              mode_d = sbt_pkg::ModeHalt;
            end else begin
              mode_d = sbt_pkg::ModeList;
            end
          end
        end else if (c == sbt_pkg::ChQuote) begin
          ev_d[n_d] = mk_ev(sbt_pkg::EvStrStart, 8'd0, depth_q, 3'd0);
          n_d = n_d + 2'd1;
          mode_d = sbt_pkg::ModeStr;
        end else begin
          ev_d[n_d] = mk_ev(sbt_pkg::EvSymByte, c, depth_q, 3'd0);
          n_d = n_d + 2'd1;
          mode_d = sbt_pkg::ModeSym;
        end
      end
    end

    for (int i = 0; i < sbt_pkg::MaxEvents; i++) begin
      ev_d[i].last_of_run = (n_d == sbt_pkg::EvCntW'(i + 1));
    end
  end

  assign batch_o.count = n_d;
  assign batch_o.ev    = ev_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= sbt_pkg::ModeIdle;
      depth_q <= 8'd0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      depth_q <= depth_d;
    end
  end

  `SBT_ASSERT(a_depth_bounded, clk_i, rst_ni, depth_q <= 8'(MaxNesting))
  `SBT_ASSERT(a_eot_rearms, clk_i, rst_ni, accept_i && in_data_i.end_of_text |=> mode_q == sbt_pkg::ModeIdle && depth_q == 8'd0)
  `SBT_ASSERT(a_halt_silent, clk_i, rst_ni, mode_q == sbt_pkg::ModeHalt && !in_data_i.end_of_text |-> batch_o.count == 2'd0)

endmodule

// File: rtl/core/sbt_event_fifo.sv
// Three-entry result buffer that drains the events of one byte, one per beat.
// Depends on sbt_pkg and sexpr_byte_tokenizer_defines.svh.
`include "sexpr_byte_tokenizer_defines.svh"
module sbt_event_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  sbt_pkg::sbt_batch_t batch_i,
  output logic                load_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sbt_pkg::sbt_out_t   out_data_o
);

  sbt_pkg::sbt_out_t [sbt_pkg::MaxEvents-1:0] slot_q, slot_d;
  logic [sbt_pkg::EvCntW-1:0] count_q, count_d;
  logic pop;

  assign out_valid_o  = (count_q != '0);
  assign pop          = out_valid_o && out_ready_i;
  assign load_ready_o = (count_q == '0) || (count_q == 2'd1 && out_ready_i);
  assign out_data_o   = slot_q[0];

  always_comb begin
    slot_d  = slot_q;
    count_d = count_q;
    if (load_i) begin
      slot_d  = batch_i.ev;
      count_d = batch_i.count;
    end else if (pop) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
      count_d   = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  `SBT_ASSERT(a_load_count, clk_i, rst_ni, load_i |=> count_q == $past(batch_i.count))
  `SBT_ASSERT(a_pop_count, clk_i, rst_ni, pop && !load_i |=> count_q == $past(count_q) - 2'd1)
  `SBT_ASSERT(a_load_when_drained, clk_i, rst_ni, load_i |-> count_q == 2'd0 || (count_q == 2'd1 && pop))

endmodule

// File: rtl/core/sexpr_byte_tokenizer.sv
// Top level of the S-expression byte tokenizer: lexer plus result buffer.
// Depends on sbt_pkg, sbt_lexer and sbt_event_fifo.
//
//   channel | direction | payload            | handshake
//   in      | sink      | sbt_pkg::sbt_in_t  | in_valid_i / in_ready_o
//   out     | source    | sbt_pkg::sbt_out_t | out_valid_o / out_ready_i
//
// A byte is lexed in the cycle it is accepted and its events land in the result buffer
// at the next edge, so the first event appears in the cycle after acceptance.
// Bytes that yield at most one event flow at one per cycle while the output is ready; a byte
// with several events stalls the input while the single event port drains the buffer.
// Reset clears the lexer to idle at depth zero and empties the buffer.
// A stalled output holds the current event and blocks input once the buffer is busy.
module sexpr_byte_tokenizer #(
  parameter int MaxNesting = sbt_pkg::MaxNestingDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sbt_pkg::sbt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sbt_pkg::sbt_out_t out_data_o
);

  sbt_pkg::sbt_batch_t batch;
  logic accept;

  assign accept = in_valid_i && in_ready_o;

  sbt_lexer #(
    .MaxNesting(MaxNesting)
  ) u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .batch_o   (batch)
  );

  sbt_event_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .batch_i      (batch),
    .load_ready_o (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// File: tb/sexpr_byte_tokenizer_test.sv
// Self-checking testbench for sexpr_byte_tokenizer: random documents in, events checked.
// Depends on sbt_pkg and the sexpr_byte_tokenizer RTL; needs no files or arguments.
`timescale 1ns / 1ps

module sexpr_byte_tokenizer_test;
  import sbt_pkg::*;

  localparam int Nesting = MaxNestingDef;
  localparam logic [2:0] ErrNone = 3'd0;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  sbt_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  sbt_out_t out_data_o;

  sexpr_byte_tokenizer #(
    .MaxNesting(Nesting)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  sbt_in_t    pending_beats[$];
  sbt_out_t   expected_events[$];
  sbt_out_t   beat_events[$];
  logic [7:0] doc_text[$];

  mode_e lex_mode;
  int    nest_depth;

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  in_taken;
  int  counted_beats;
  int  beats_taken;
  int  events_checked;
  int  docs_done;
  int  error_events;
  int  mismatch_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("sexpr_byte_tokenizer_test: done, errors");
    $finish;
  end

  // Character classes.
  function automatic bit is_blank(logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChLf || c == ChCr;
  endfunction

  function automatic bit is_delim(logic [7:0] c);
    return is_blank(c) || c == ChLParen || c == ChRParen || c == ChQuote;
  endfunction

  // Predictor of the token events.
  function automatic void add_event(event_kind_e kind, logic [7:0] ch, logic [2:0] err);
    sbt_out_t ev;
    ev.event_kind  = kind;
    ev.char_value  = ch;
    ev.nest_level  = nest_depth[7:0];
    ev.error_code  = err;
    ev.last_of_run = 1'b0;
    beat_events.insert(beat_events.size(), ev);
  endfunction

  function automatic void lex_fail(error_code_e err);
    add_event(EvError, 8'h00, err);
    lex_mode = ModeHalt;
  endfunction

  function automatic void lex_token_start(logic [7:0] c);
    if (is_blank(c)) begin
    end else if (c == ChLParen) begin
      if (nest_depth + 1 > Nesting) begin
        lex_fail(ErrDeep);
      end else begin
        nest_depth++;
        add_event(EvOpen, 8'h00, ErrNone);
        lex_mode = ModeList;
      end
    end else if (c == ChRParen) begin
      if (nest_depth == 0) begin
        lex_fail(ErrClose);
      end else begin
        nest_depth--;
        add_event(EvClose, 8'h00, ErrNone);
        if (nest_depth == 0) begin
          add_event(EvDone, 8'h00, ErrNone);
          lex_mode = ModeHalt;
        end else begin
          lex_mode = ModeList;
        end
      end
    end else if (c == ChQuote) begin
      add_event(EvStrStart, 8'h00, ErrNone);
      lex_mode = ModeStr;
    end else begin
      add_event(EvSymByte, c, ErrNone);
      lex_mode = ModeSym;
    end
  endfunction

  function automatic void lex_byte(logic [7:0] c);
    case (lex_mode)
      ModeIdle, ModeList: lex_token_start(c);
      ModeSym: begin
        if (!is_delim(c)) begin
          add_event(EvSymByte, c, ErrNone);
        end else begin
          add_event(EvSymEnd, 8'h00, ErrNone);
          if (nest_depth == 0) begin
            add_event(EvDone, 8'h00, ErrNone);
            lex_mode = ModeHalt;
          end else begin
            lex_mode = ModeList;
            lex_token_start(c);
          end
        end
      end
      ModeStr: begin
        if (c == ChBackslash) begin
          lex_mode = ModeEsc;
        end else if (c == ChQuote) begin
          add_event(EvStrEnd, 8'h00, ErrNone);
          if (nest_depth == 0) begin
            add_event(EvDone, 8'h00, ErrNone);
            lex_mode = ModeHalt;
          end else begin
            lex_mode = ModeList;
          end
        end else begin
          add_event(EvStrByte, c, ErrNone);
        end
      end
      ModeEsc: begin
        add_event(EvStrByte, c, ErrNone);
        lex_mode = ModeStr;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void lex_end();
    case (lex_mode)
      ModeIdle: lex_fail(ErrEmpty);
      ModeList: lex_fail(ErrUnbal);
      ModeSym: begin
        add_event(EvSymEnd, 8'h00, ErrNone);
        if (nest_depth == 0) begin
          add_event(EvDone, 8'h00, ErrNone);
        end else begin
          lex_fail(ErrUnbal);
        end
      end
      ModeStr, ModeEsc: lex_fail(ErrUnterm);
      default: begin
      end
    endcase
    lex_mode   = ModeIdle;
    nest_depth = 0;
  endfunction

  function automatic void tokenize_beat(sbt_in_t b);
    beat_events.delete();
    if (b.end_of_text) begin
      lex_end();
    end else begin
      lex_byte(b.data_byte);
    end
    if (beat_events.size() != 0) begin
      beat_events[beat_events.size() - 1].last_of_run = 1'b1;
    end
    foreach (beat_events[i]) expected_events.insert(expected_events.size(), beat_events[i]);
  endfunction

  // Checking.
  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic check_event(sbt_out_t got);
    sbt_out_t want;
    if (got.event_kind == EvDone) docs_done++;
    if (got.event_kind == EvError) error_events++;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("event of kind %0d with none expected", got.event_kind));
    end else begin
      want = expected_events.pop_front();
      events_checked++;
      compare_field("event_kind", got.event_kind, want.event_kind);
      compare_field("char_value", got.char_value, want.char_value);
      compare_field("nest_level", got.nest_level, want.nest_level);
      compare_field("error_code", got.error_code, want.error_code);
      compare_field("last_of_run", got.last_of_run, want.last_of_run);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_event(out_data_o);
      if (in_valid_i && in_ready_o) begin
        in_taken = 1'b1;
        beats_taken++;
        tokenize_beat(in_data_i);
      end
    end
  end

  always @(negedge clk_i) begin
    bit keep_valid;
    keep_valid = in_valid_i && !in_taken;
    in_taken   = 1'b0;
    if (rst_ni && !keep_valid && pending_beats.size() != 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      in_data_i <= pending_beats.pop_front();
      keep_valid = 1'b1;
    end
    in_valid_i  <= rst_ni && keep_valid;
    out_ready_i <= $urandom_range(99) >= recv_stall_pct;
  end

  // Stimulus.
  function automatic void put_text(logic [7:0] c);
    doc_text.insert(doc_text.size(), c);
  endfunction

  task automatic queue_beat(logic [7:0] c, bit counted);
    sbt_in_t b;
    b.data_byte   = c;
    b.end_of_text = 1'b0;
    pending_beats.insert(pending_beats.size(), b);
    if (counted) counted_beats++;
  endtask

  task automatic queue_end();
    sbt_in_t b;
    b.data_byte   = 8'($urandom_range(255));
    b.end_of_text = 1'b1;
    pending_beats.insert(pending_beats.size(), b);
    counted_beats++;
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_beat(s[i], 1'b1);
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(3))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChLf;
      default: return ChCr;
    endcase
  endfunction

  function automatic logic [7:0] delim_char();
    case ($urandom_range(3))
      0:       return blank_char();
      1:       return ChLParen;
      2:       return ChRParen;
      default: return ChQuote;
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    if ($urandom_range(1)) return 8'($urandom_range(255));
    case ($urandom_range(3))
      0:       return delim_char();
      1:       return ChBackslash;
      2:       return ChQuote;
      default: return ChLParen;
    endcase
  endfunction

  function automatic logic [7:0] sym_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (is_delim(c));
    return c;
  endfunction

  function automatic logic [7:0] str_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == ChQuote || c == ChBackslash);
    return c;
  endfunction

  task automatic gen_element(int lvl, int max_lvl);
    int pick;
    int n;
    pick = $urandom_range(lvl < max_lvl ? 2 : 1);
    case (pick)
      0: begin
        n = $urandom_range(3, 1);
        repeat (n) put_text(sym_char());
      end
      1: begin
        put_text(ChQuote);
        n = $urandom_range(3);
        repeat (n) begin
          if ($urandom_range(3) == 0) begin
            put_text(ChBackslash);
            put_text(8'($urandom_range(255)));
          end else begin
            put_text(str_char());
          end
        end
        put_text(ChQuote);
      end
      default: begin
        put_text(ChLParen);
        if ($urandom_range(1)) put_text(blank_char());
        n = $urandom_range(lvl < 1 ? 3 : 2);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put_text(blank_char());
          gen_element(lvl + 1, max_lvl);
        end
        if ($urandom_range(1)) put_text(blank_char());
        put_text(ChRParen);
      end
    endcase
  endtask

  task automatic add_document(bit truncate);
    int  keep_len;
    bit  open_atom;
    doc_text.delete();
    gen_element(0, $urandom_range(3, 1));
    if (truncate) begin
      keep_len = $urandom_range(doc_text.size() - 1);
      while (doc_text.size() > keep_len) void'(doc_text.pop_back());
      foreach (doc_text[i]) queue_beat(doc_text[i], 1'b1);
    end else begin
      open_atom = !is_delim(doc_text[doc_text.size() - 1]);
      if (open_atom && $urandom_range(1)) begin
        put_text(delim_char());
        open_atom = 1'b0;
      end
      foreach (doc_text[i]) queue_beat(doc_text[i], 1'b1);
      if (!open_atom) repeat ($urandom_range(2)) queue_beat(noise_char(), 1'b0);
    end
    queue_end();
  endtask

  task automatic add_deep(int depth);
    repeat (depth) queue_beat(ChLParen, 1'b1);
    queue_beat(sym_char(), 1'b1);
    repeat (depth) queue_beat(ChRParen, 1'b1);
    queue_end();
  endtask

  task automatic add_sequence();
    int r;
    r = $urandom_range(99);
    if (r < 65) begin
      add_document(1'b0);
    end else if (r < 75) begin
      add_deep($urandom_range(Nesting + 1, Nesting - 1));
    end else if (r < 85) begin
      add_document(1'b1);
    end else if (r < 93) begin
      repeat ($urandom_range(6, 1)) queue_beat(noise_char(), 1'b1);
      queue_end();
    end else begin
      queue_beat(ChRParen, 1'b1);
      repeat ($urandom_range(2)) queue_beat(noise_char(), 1'b0);
      queue_end();
    end
  endtask

  task automatic queue_directed();
    queue_end();
    queue_text(")");
    queue_end();
    queue_text("ab ");
    queue_end();
    queue_text("(x)");
    queue_end();
    queue_text("\"q\\\"\"zz");
    queue_end();
    queue_text("(\"");
    queue_end();
    queue_text("( k");
    queue_end();
    queue_text("(");
    queue_end();
    queue_beat(8'hFF, 1'b1);
    queue_end();
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_beats.size() != 0 || in_valid_i || expected_events.size() != 0);
  endtask

  initial begin
    int mark;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    in_taken       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    lex_mode       = ModeIdle;
    nest_depth     = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_directed();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      if (phase == 0) begin
        add_deep(Nesting);
        add_deep(Nesting + 1);
      end
      mark = counted_beats;
      while (counted_beats - mark < 30) add_sequence();
      wait_drained();
    end
    repeat (20) @(posedge clk_i);

    $display("Sent %0d beats over four flow-control phases; %0d events checked.",
             beats_taken, events_checked);
    $display("Documents completed: %0d, error events: %0d, mismatches: %0d.",
             docs_done, error_events, mismatch_count);
    if (mismatch_count == 0) begin
      $display("sexpr_byte_tokenizer_test: done, clean");
    end else begin
      $display("sexpr_byte_tokenizer_test: done, errors");
    end
    $finish;
  end

endmodule
